// File: rtl/core/bc1d_pkg.sv
// Shared types, constants and helper functions of the BC1 block decoder.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none
package bc1d_pkg;

  // One BC1 block as it arrives on the request side
  typedef struct packed {
    logic [15:0] color_a;
    logic [15:0] color_b;
    logic [31:0] index_bits;
  } in_item_t;

  // One decoded pixel row
  typedef struct packed {
    logic [23:0] pixel0_rgb;
    logic [23:0] pixel1_rgb;
    logic [23:0] pixel2_rgb;
    logic [23:0] pixel3_rgb;
    logic [11:0] dest_x;
    logic [12:0] dest_y;
    logic        last_row;
  } out_item_t;

  typedef logic [3:0][23:0] palette_t;

  // Classified block held between front and back end
  typedef struct packed {
    palette_t    pal;
    logic [31:0] index_bits;
    logic [11:0] dest_x;
    logic [12:0] dest_y;
  } blk_t;

  localparam int          MaxWidthDefault = 4096;
  localparam int          ColSpan         = 4096;
  localparam logic [12:0] ImageWidthReset = 13'd256;
  localparam int          QueueDepth      = 2;
  localparam int          RowsPerBlock    = 4;
  localparam logic [1:0]  LastRowIdx      = 2'd3;
  localparam logic        RegImageWidth   = 1'b0;

  // Truncating divide by three for values below 768: multiply by 683/2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/bc1_texture_block_decoder_unit.sv
// Top level of the BC1 texture block decoder: APB register decode and the
// front end, block queue and back end. Depends on bc1d_pkg and rtl/core modules.
`default_nettype none
// Decodes one 64-bit BC1 (DXT1) block per request into four pixel-row results,
// top row first, each carrying four RGB888 pixels and the image position of
// the row. Endpoints expand to RGB888 by shift only; when color_a > color_b the
// palette adds truncated 2/3-1/3 blends, otherwise the truncated average and
// black. A block is taken whenever the internal two-block queue has room; the
// back end then drives one row per cycle into the result register while the
// result side keeps popping. The first row of a request passes through the
// block queue and then the result register to reach the result ports.
// Position counters step the column by four and wrap at image_width (or at
// MAX_WIDTH, capped at 4096), then advance the row by four modulo 8192.
// image_width sits at APB address 0 (reset 256); writing it clears the
// position. Write it only while no block is in flight.
module bc1_texture_block_decoder_unit #(
  parameter int MAX_WIDTH = bc1d_pkg::MaxWidthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request side
  input  wire logic                push_i,
  input  wire bc1d_pkg::in_item_t  in_item_i,
  output logic                     full_o,
  // result side
  input  wire logic                pop_i,
  output logic                     empty_o,
  output bc1d_pkg::out_item_t      out_item_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic           cfg_we;
  logic [12:0]    image_width;
  logic           q_push, q_pop, q_full, q_empty;
  bc1d_pkg::blk_t q_wr_blk, q_rd_blk;

  // Decode the register index from the word address; the only register
  // is image_width, anything else reads as zero and ignores writes.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == bc1d_pkg::RegImageWidth);
  assign prdata = (paddr[2] == bc1d_pkg::RegImageWidth) ? {19'd0, image_width} : 32'd0;

  // Front end: classify the block, build its palette, tag its position
  bc1d_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .in_item_i     (in_item_i),
    .q_full_i      (q_full),
    .cfg_we_i      (cfg_we),
    .cfg_width_i   (pwdata[12:0]),
    .full_o        (full_o),
    .q_push_o      (q_push),
    .q_blk_o       (q_wr_blk),
    .image_width_o (image_width)
  );

  // Hold classified blocks so either side can stall on its own
  bc1d_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wr_blk_i (q_wr_blk),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .empty_o  (q_empty),
    .rd_blk_o (q_rd_blk)
  );

  // Back end: emit one row per cycle while the result side keeps up, drop the block after its last row
  bc1d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_blk_i    (q_rd_blk),
    .pop_i      (pop_i),
    .q_pop_o    (q_pop),
    .empty_o    (empty_o),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/bc1d_front.sv
// Front end: takes BC1 blocks, builds the four-entry palette and tags the block
// with its image position. Depends on bc1d_pkg.
`default_nettype none
module bc1d_front #(
  parameter int MAX_WIDTH = bc1d_pkg::MaxWidthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bc1d_pkg::in_item_t in_item_i,
  input  wire logic              q_full_i,
  input  wire logic              cfg_we_i,
  input  wire logic [12:0]       cfg_width_i,
  output logic                   full_o,
  output logic                   q_push_o,
  output bc1d_pkg::blk_t         q_blk_o,
  output logic [12:0]            image_width_o
);

  localparam int WrapLimitInt =
    (MAX_WIDTH < bc1d_pkg::ColSpan) ? MAX_WIDTH : bc1d_pkg::ColSpan;
  localparam logic [12:0] WrapLimit = 13'(WrapLimitInt);

  logic [12:0] width_q;
  logic [11:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [12:0] next_col;
  logic        wrap;

  logic [7:0] ar, ag, ab, br, bg, bb;
  logic [7:0] p2r, p2g, p2b, p3r, p3g, p3b;
  logic       four_colour;

  assign full_o        = q_full_i;
  assign q_push_o      = push_i & ~q_full_i;
  assign image_width_o = width_q;

  // expand endpoints by shift only
  assign ar = {in_item_i.color_a[15:11], 3'b000};
  assign ag = {in_item_i.color_a[10:5], 2'b00};
  assign ab = {in_item_i.color_a[4:0], 3'b000};
  assign br = {in_item_i.color_b[15:11], 3'b000};
  assign bg = {in_item_i.color_b[10:5], 2'b00};
  assign bb = {in_item_i.color_b[4:0], 3'b000};

  assign four_colour = in_item_i.color_a > in_item_i.color_b;

  always_comb begin
    if (four_colour) begin
      p2r = bc1d_pkg::div3({1'b0, ar, 1'b0} + 10'(br));
      p2g = bc1d_pkg::div3({1'b0, ag, 1'b0} + 10'(bg));
      p2b = bc1d_pkg::div3({1'b0, ab, 1'b0} + 10'(bb));
      p3r = bc1d_pkg::div3(10'(ar) + {1'b0, br, 1'b0});
      p3g = bc1d_pkg::div3(10'(ag) + {1'b0, bg, 1'b0});
      p3b = bc1d_pkg::div3(10'(ab) + {1'b0, bb, 1'b0});
    end else begin
      p2r = 8'((9'(ar) + 9'(br)) >> 1);
      p2g = 8'((9'(ag) + 9'(bg)) >> 1);
      p2b = 8'((9'(ab) + 9'(bb)) >> 1);
      p3r = 8'd0;
      p3g = 8'd0;
      p3b = 8'd0;
    end
  end

  always_comb begin
    q_blk_o.pal[0]     = {ar, ag, ab};
    q_blk_o.pal[1]     = {br, bg, bb};
    q_blk_o.pal[2]     = {p2r, p2g, p2b};
    q_blk_o.pal[3]     = {p3r, p3g, p3b};
    q_blk_o.index_bits = in_item_i.index_bits;
    q_blk_o.dest_x     = col_q;
    q_blk_o.dest_y     = row_q;
  end

  // raster position advance
  assign next_col = {1'b0, col_q} + 13'd4;
  assign wrap     = (next_col >= width_q) || (next_col >= WrapLimit);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (q_push_o) begin
      if (wrap) begin
        col_d = '0;
        row_d = row_q + 13'd4;
      end else begin
        col_d = next_col[11:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= bc1d_pkg::ImageWidthReset;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      if (cfg_we_i) width_q <= cfg_width_i;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bc1d_queue.sv
// Short block queue between front and back end.
// Depends on bc1d_pkg.
`default_nettype none
module bc1d_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bc1d_pkg::blk_t wr_blk_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output bc1d_pkg::blk_t      rd_blk_o
);

  localparam int PtrW = (bc1d_pkg::QueueDepth > 1) ? $clog2(bc1d_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(bc1d_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Depth   = CntW'(bc1d_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(bc1d_pkg::QueueDepth - 1);

  bc1d_pkg::blk_t          mem_q [bc1d_pkg::QueueDepth];
  logic [PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]         count_q;
  logic                    do_push, do_pop;

  assign full_o   = (count_q == Depth);
  assign empty_o  = (count_q == '0);
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & ~empty_o;
  assign rd_blk_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_blk_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bc1d_back.sv
// Back end: walks the four rows of the queued block and holds each decoded row
// in the result register. Depends on bc1d_pkg.
`default_nettype none
module bc1d_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire bc1d_pkg::blk_t q_blk_i,
  input  wire logic           pop_i,
  output logic                q_pop_o,
  output logic                empty_o,
  output bc1d_pkg::out_item_t out_item_o
);

  logic                valid_q;
  logic [1:0]          row_q;
  bc1d_pkg::out_item_t out_q, out_d;
  logic                load;
  logic [7:0]          idx;

  assign empty_o    = ~valid_q;
  assign out_item_o = out_q;
  // load the next row when the result register is free or being drained
  assign load       = ~q_empty_i & (~valid_q | pop_i);
  assign q_pop_o    = load & (row_q == bc1d_pkg::LastRowIdx);
  assign idx        = q_blk_i.index_bits[{row_q, 3'b000} +: 8];

  always_comb begin
    out_d.pixel0_rgb = q_blk_i.pal[idx[1:0]];
    out_d.pixel1_rgb = q_blk_i.pal[idx[3:2]];
    out_d.pixel2_rgb = q_blk_i.pal[idx[5:4]];
    out_d.pixel3_rgb = q_blk_i.pal[idx[7:6]];
    out_d.dest_x     = q_blk_i.dest_x;
    out_d.dest_y     = q_blk_i.dest_y + 13'(row_q);
    out_d.last_row   = (row_q == bc1d_pkg::LastRowIdx);
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row_q   <= '0;
    end else begin
      if (load)        valid_q <= 1'b1;
      else if (pop_i)  valid_q <= 1'b0;
      if (load)        row_q   <= row_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for bc1_texture_block_decoder_unit: BC1 block requests
// in, pixel rows out, compared against a predictor of its own.
// Depends on bc1d_pkg and the RTL under rtl/core; reads no files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MaxWidth   = bc1d_pkg::MaxWidthDefault;
  localparam logic [2:0]  WidthAddr  = 3'({bc1d_pkg::RegImageWidth, 2'b00});
  localparam int          SettleWait = 8;
  localparam int          PrintLimit = 40;

  // receiver behaviour: always ready, random stalls, fixed stall pattern
  typedef enum int {POP_ALWAYS, POP_RANDOM, POP_PATTERN} pop_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  bc1d_pkg::in_item_t  in_item_i;
  logic                full_o;
  logic                pop_i;
  logic                empty_o;
  bc1d_pkg::out_item_t out_item_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // predictor copy of the register and the position counters
  logic [12:0] width_q;
  logic [11:0] col_q;
  logic [12:0] row_q;

  bc1d_pkg::out_item_t expected_rows[$];
  bc1d_pkg::out_item_t due_row;
  int          mismatches;
  int          burst_left;
  bit          gaps_on;
  pop_mode_e   pop_mode;
  int          pop_beat;

  bc1_texture_block_decoder_unit #(
    .MAX_WIDTH(MaxWidth)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_item_i (in_item_i),
    .full_o    (full_o),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .out_item_o(out_item_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Reporting and prediction
  // ---------------------------------------------------------------------------

  // Print one line per mismatch (up to a limit, so a dead block cannot flood
  // the log) and count every one.
  task automatic report(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("[%0t] row error: %s got %0h want %0h", $time, what, got, want);
  endtask

  function automatic logic [23:0] pack_rgb(int r, int g, int b);
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  // Decode one block into its four expected rows, then step the position the
  // way the block does: column by four, wrap to the next block row.
  task automatic decode_block(bc1d_pkg::in_item_t blk);
    int        ar, ag, ab, br, bg, bb;
    int        nxt;
    logic [7:0] sel;
    logic [3:0][23:0] pal;
    bc1d_pkg::out_item_t row;
    ar = int'(blk.color_a[15:11]) << 3;
    ag = int'(blk.color_a[10:5]) << 2;
    ab = int'(blk.color_a[4:0]) << 3;
    br = int'(blk.color_b[15:11]) << 3;
    bg = int'(blk.color_b[10:5]) << 2;
    bb = int'(blk.color_b[4:0]) << 3;
    pal[0] = pack_rgb(ar, ag, ab);
    pal[1] = pack_rgb(br, bg, bb);
    if (blk.color_a > blk.color_b) begin
      // four-colour block: two truncated thirds between the endpoints
      pal[2] = pack_rgb((2 * ar + br) / 3, (2 * ag + bg) / 3, (2 * ab + bb) / 3);
      pal[3] = pack_rgb((ar + 2 * br) / 3, (ag + 2 * bg) / 3, (ab + 2 * bb) / 3);
    end else begin
      // three-colour block, equal endpoints included: average and black
      pal[2] = pack_rgb((ar + br) / 2, (ag + bg) / 2, (ab + bb) / 2);
      pal[3] = '0;
    end
    for (int r = 0; r < bc1d_pkg::RowsPerBlock; r++) begin
      sel = blk.index_bits[8 * r +: 8];
      row.pixel0_rgb = pal[sel[1:0]];
      row.pixel1_rgb = pal[sel[3:2]];
      row.pixel2_rgb = pal[sel[5:4]];
      row.pixel3_rgb = pal[sel[7:6]];
      row.dest_x     = col_q;
      row.dest_y     = 13'(row_q + r);
      row.last_row   = (r == bc1d_pkg::RowsPerBlock - 1);
      expected_rows.insert(expected_rows.size(), row);
    end
    nxt = int'(col_q) + 4;
    if (nxt >= int'(width_q) || nxt >= MaxWidth || nxt > 4095) begin
      col_q = '0;
      row_q = 13'(row_q + 4);
    end else begin
      col_q = 12'(nxt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Send one block request. The sender works in bursts; between bursts it
  // drops push for a random gap. Prediction happens at the accepting edge.
  task automatic send_block(bc1d_pkg::in_item_t blk);
    int gap;
    if (burst_left == 0) begin
      burst_left = gaps_on ? $urandom_range(1, 8) : 64;
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        push_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    push_i    <= 1'b1;
    in_item_i <= blk;
    do @(posedge clk_i); while (full_o);
    decode_block(blk);
  endtask

  // Drop push and wait until every predicted row has been popped, then let
  // the pipeline settle before anything touches the register.
  task automatic settle();
    @(negedge clk_i);
    push_i     <= 1'b0;
    burst_left = 0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // APB write of image_width followed by a read-back of the same register.
  task automatic write_width(int value);
    logic [12:0] w;
    w = 13'(value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WidthAddr;
    pwdata  <= 32'(w);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    width_q = w;
    col_q   = '0;
    row_q   = '0;
    // read back: hold psel, restart with a setup cycle
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[12:0] !== w)
      report("image_width read-back", prdata[12:0], w);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random block content: mostly independent endpoints, with a share of
  // equal endpoints, neighbouring endpoints and saturated channels.
  function automatic bc1d_pkg::in_item_t random_block();
    bc1d_pkg::in_item_t b;
    int       pick;
    b.color_a    = 16'($urandom);
    b.color_b    = 16'($urandom);
    b.index_bits = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      b.color_b = b.color_a;
    end else if (pick < 25) begin
      b.color_b = b.color_a - 16'd1;
    end else if (pick < 30) begin
      b.color_b = b.color_a + 16'd1;
    end else if (pick < 40) begin
      b.color_a = {{5{$urandom_range(0, 1) == 1}}, {6{$urandom_range(0, 1) == 1}},
                   {5{$urandom_range(0, 1) == 1}}};
      b.color_b = {{5{$urandom_range(0, 1) == 1}}, {6{$urandom_range(0, 1) == 1}},
                   {5{$urandom_range(0, 1) == 1}}};
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and row checker
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    pop_beat++;
    case (pop_mode)
      POP_ALWAYS:  pop_i <= 1'b1;
      POP_RANDOM:  pop_i <= ($urandom_range(0, 99) >= 40);
      POP_PATTERN: pop_i <= ((pop_beat % 7) >= 3);
      default:     pop_i <= 1'b1;
    endcase
  end

  // Compare each popped row, field by field, with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_rows.size() == 0) begin
        report("row with nothing expected, dest_y", out_item_o.dest_y, 0);
      end else begin
        due_row = expected_rows.pop_front();
        if (out_item_o.pixel0_rgb !== due_row.pixel0_rgb)
          report("pixel0_rgb", out_item_o.pixel0_rgb, due_row.pixel0_rgb);
        if (out_item_o.pixel1_rgb !== due_row.pixel1_rgb)
          report("pixel1_rgb", out_item_o.pixel1_rgb, due_row.pixel1_rgb);
        if (out_item_o.pixel2_rgb !== due_row.pixel2_rgb)
          report("pixel2_rgb", out_item_o.pixel2_rgb, due_row.pixel2_rgb);
        if (out_item_o.pixel3_rgb !== due_row.pixel3_rgb)
          report("pixel3_rgb", out_item_o.pixel3_rgb, due_row.pixel3_rgb);
        if (out_item_o.dest_x !== due_row.dest_x)
          report("dest_x", out_item_o.dest_x, due_row.dest_x);
        if (out_item_o.dest_y !== due_row.dest_y)
          report("dest_y", out_item_o.dest_y, due_row.dest_y);
        if (out_item_o.last_row !== due_row.last_row)
          report("last_row", out_item_o.last_row, due_row.last_row);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed blocks at the reset width of 256: palette selection on both
  // sides of the endpoint compare, equal endpoints (black entry), extreme
  // colours and every index value.
  task automatic test_palette_corners();
    bc1d_pkg::in_item_t b;
    logic [15:0] ca[12] = '{16'hFFFF, 16'h0000, 16'h8410, 16'h0000, 16'hFFFF, 16'h0001,
                            16'hF800, 16'h07E0, 16'h001F, 16'hFFFF, 16'h7BEF, 16'hF81F};
    logic [15:0] cb[12] = '{16'h0000, 16'hFFFF, 16'h8410, 16'h0000, 16'hFFFF, 16'h0000,
                            16'h07E0, 16'hF800, 16'h07FF, 16'hFFFE, 16'h8410, 16'h07E0};
    logic [31:0] ix[6]  = '{32'hE4E4E4E4, 32'h1B1B1B1B, 32'h00000000,
                            32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA};
    gaps_on  = 1'b1;
    pop_mode = POP_RANDOM;
    for (int i = 0; i < 12; i++) begin
      b.color_a    = ca[i];
      b.color_b    = cb[i];
      b.index_bits = ix[i % 6];
      send_block(b);
    end
    // one more with black selected everywhere on an equal-endpoint block
    b.color_a    = 16'h5555;
    b.color_b    = 16'h5555;
    b.index_bits = 32'hFFFFFFFF;
    send_block(b);
    settle();
  endtask

  // Widths below four wrap every block; five wraps after two columns.
  task automatic test_small_widths();
    int widths[6] = '{0, 1, 3, 4, 5, 8};
    gaps_on  = 1'b1;
    pop_mode = POP_PATTERN;
    foreach (widths[i]) begin
      write_width(widths[i]);
      repeat (4) send_block(random_block());
      settle();
    end
  endtask

  // Main random traffic across several widths and idling styles, one phase
  // with no idling at all.
  task automatic test_random_traffic();
    int widths[7];
    widths = '{4, 8, 12, 20, 64, $urandom_range(4, 128), 256};
    for (int p = 0; p < 7; p++) begin
      write_width(widths[p]);
      gaps_on  = (p != 3);
      pop_mode = (p == 3) ? POP_ALWAYS : ((p % 2 == 0) ? POP_RANDOM : POP_PATTERN);
      repeat (20) send_block(random_block());
      settle();
    end
  endtask

  // Widths at the 4096 cap and at the largest value the register holds:
  // the column keeps stepping by four with no early wrap.
  task automatic test_column_cap();
    gaps_on  = 1'b0;
    pop_mode = POP_ALWAYS;
    write_width(4096);
    repeat (10) send_block(random_block());
    settle();
    pop_mode = POP_PATTERN;
    write_width(8191);
    repeat (10) send_block(random_block());
    settle();
  endtask

  // Width four gives one block per block row: dest_y advances by four on
  // every block while dest_x stays at zero.
  task automatic test_row_step();
    gaps_on  = 1'b0;
    pop_mode = POP_ALWAYS;
    write_width(4);
    repeat (12) send_block(random_block());
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni     = 1'b0;
    push_i     = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    pop_mode   = POP_ALWAYS;
    pop_beat   = 0;
    width_q    = bc1d_pkg::ImageWidthReset;
    col_q      = '0;
    row_q      = '0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_palette_corners();
    test_small_widths();
    test_random_traffic();
    test_column_cap();
    test_row_step();
    write_width(bc1d_pkg::ImageWidthReset);

    repeat (SettleWait) @(posedge clk_i);
    if (expected_rows.size() != 0)
      report("rows never delivered", 0, expected_rows.size());
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bc1d_pkg.sv
rtl/core/bc1d_front.sv
rtl/core/bc1d_queue.sv
rtl/core/bc1d_back.sv
rtl/core/bc1_texture_block_decoder_unit.sv
tb/sv/tb_top.sv
